FILE: rtl/core/fixed_frame_builder_top_defines.svh
`ifndef FIXED_FRAME_BUILDER_TOP_DEFINES_SVH
`define FIXED_FRAME_BUILDER_TOP_DEFINES_SVH

// same-cycle check: when cond holds, prop holds too
`define FFB_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("ffb check failed");

// next-cycle check: when cond holds, prop holds in the next cycle
`define FFB_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("ffb check failed");

`endif

FILE: rtl/core/ffb_pkg.sv
`default_nettype none

package ffb_pkg;

	localparam int MAX_FRAME   = 1024;
	localparam int MIN_FRAME   = 17;
	localparam int TRAILER_LEN = 16;

	localparam int CFG_W = 11;
	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam int POS_W = $clog2(MAX_FRAME);

	localparam int VAL_W       = 24;
	localparam int IDX_W       = 3;
	localparam int RECIP_W     = 25;
	localparam int SHIFT_W     = 6;
	localparam int PROD_W      = VAL_W + RECIP_W;
	localparam int DIV10_W     = 24;
	localparam int DIV10_SHIFT = 27;
	localparam logic [DIV10_W-1:0] DIV10_M = 24'd13421773;

	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam logic [7:0] ASCII_ONE  = 8'd49;

	localparam logic REG_FRAME_LENGTH = 1'b0;
	localparam logic REG_PAD_CHAR     = 1'b1;

	localparam logic [CFG_W-1:0] FRAME_LENGTH_RST = 11'd1000;
	localparam logic [7:0]       PAD_CHAR_RST     = 8'd35;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// one classified byte waiting for the back end
	typedef struct packed {
		logic             is_digit;
		logic [7:0]       byte_val;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] digit_idx;
		logic             last;
		logic             dropped;
	} entry_t;

	typedef struct packed {
		logic                   full;
		logic                   empty;
		logic [QUEUE_CNT_W-1:0] level;
	} queue_status_t;

	// floor(v / 10^k) == (v * recip_of(k)) >> shift_of(k) for k from 0 to 6 and any 24-bit v
	function automatic logic [RECIP_W-1:0] recip_of(input logic [IDX_W-1:0] k);
		logic [RECIP_W-1:0] r;
		unique case (k)
			3'd1:    r = 25'd26843546;
			3'd2:    r = 25'd21474837;
			3'd3:    r = 25'd17179870;
			3'd4:    r = 25'd27487791;
			3'd5:    r = 25'd21990233;
			3'd6:    r = 25'd17592187;
			default: r = 25'd16777216;
		endcase
		return r;
	endfunction

	function automatic logic [SHIFT_W-1:0] shift_of(input logic [IDX_W-1:0] k);
		logic [SHIFT_W-1:0] s;
		unique case (k)
			3'd1:    s = 6'd28;
			3'd2:    s = 6'd31;
			3'd3:    s = 6'd34;
			3'd4:    s = 6'd38;
			3'd5:    s = 6'd41;
			3'd6:    s = 6'd44;
			default: s = 6'd24;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fixed_frame_builder_top.sv
// an accepted item goes into the queue, then through the back end's s1, s2 and output registers
// one item per cycle until the queue fills; front keeps all frame state, updated each transfer
// trailer digits come from a two-stage reciprocal multiply in the back end
// a four-entry queue lets the front keep taking items while the output stalls
// reset: arst_n clears frame state, the queue and the pipeline; registers return to 1000 and '#'
`default_nettype none

`include "fixed_frame_builder_top_defines.svh"

module fixed_frame_builder_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [ffb_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      mode,
	input  wire logic [7:0]                data_byte,
	input  wire logic [7:0]                frame_type,
	input  wire logic                      first_flag,
	input  wire logic [ffb_pkg::VAL_W-1:0] frame_offset,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [7:0]                     out_byte,
	output logic                           last_of_frame,
	output logic                           dropped
);

	logic [ffb_pkg::CFG_W-1:0] frame_length_q;
	logic [7:0]                pad_char_q;

	logic                  in_accept;
	logic                  back_pop;
	ffb_pkg::entry_t       front_entry;
	ffb_pkg::entry_t       q_head;
	ffb_pkg::queue_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= ffb_pkg::FRAME_LENGTH_RST;
			pad_char_q     <= ffb_pkg::PAD_CHAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ffb_pkg::REG_FRAME_LENGTH: frame_length_q <= cfg_data;
				ffb_pkg::REG_PAD_CHAR:     pad_char_q     <= cfg_data[7:0];
				default:                   frame_length_q <= frame_length_q;
			endcase
		end
	end

	assign in_ready  = !q_status.full;
	assign in_accept = in_valid && in_ready;

	ffb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_length (frame_length_q),
		.pad_char     (pad_char_q),
		.accept       (in_accept),
		.mode         (mode),
		.data_byte    (data_byte),
		.frame_type   (frame_type),
		.first_flag   (first_flag),
		.frame_offset (frame_offset),
		.entry        (front_entry)
	);

	ffb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_accept),
		.push_entry (front_entry),
		.pop        (back_pop),
		.head       (q_head),
		.status     (q_status)
	);

	ffb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.head_valid    (!q_status.empty),
		.pop           (back_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_of_frame (last_of_frame),
		.dropped       (dropped)
	);

	// a refused byte always goes out as zero
	`FFB_ASSERT_NOW(a_drop_is_zero, clk, arst_n, out_valid && dropped, out_byte == 8'd0)
	// the closing trailer byte is never a refused payload byte
	`FFB_ASSERT_NOW(a_last_not_dropped, clk, arst_n, out_valid && last_of_frame, !dropped)
	// a full queue with no pop stays full and keeps the input closed
	`FFB_ASSERT_NEXT(a_full_holds, clk, arst_n, q_status.full && !back_pop, !in_ready)
	`FFB_ASSERT_NOW(a_level_bound, clk, arst_n, 1'b1,
		q_status.level <= ffb_pkg::QUEUE_CNT_W'(ffb_pkg::QUEUE_DEPTH))

endmodule

`default_nettype wire

FILE: rtl/core/ffb_front.sv
`default_nettype none

module ffb_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [ffb_pkg::CFG_W-1:0]      frame_length,
	input  wire logic [7:0]                     pad_char,
	input  wire logic                           accept,
	input  wire logic                           mode,
	input  wire logic [7:0]                     data_byte,
	input  wire logic [7:0]                     frame_type,
	input  wire logic                           first_flag,
	input  wire logic [ffb_pkg::VAL_W-1:0]      frame_offset,
	output ffb_pkg::entry_t                     entry
);

	logic [ffb_pkg::POS_W-1:0] position_q, position_n;
	logic [ffb_pkg::POS_W-1:0] count_q, count_n;
	logic [7:0]                sum_q, sum_n;
	logic                      filling_q, filling_n;
	logic [7:0]                held_type_q;
	logic                      held_flag_q;
	logic [ffb_pkg::VAL_W-1:0] held_offset_q;

	logic [ffb_pkg::CNT_W-1:0] len_eff;
	logic [ffb_pkg::POS_W-1:0] body;
	logic [ffb_pkg::POS_W-1:0] t_full;
	logic [ffb_pkg::POS_W-1:0] padlen;
	logic [3:0]                t_idx;
	logic [7:0]                type_cur;
	logic                      flag_cur;
	logic [ffb_pkg::VAL_W-1:0] offset_cur;

	always_comb begin
		priority if (int'(frame_length) > ffb_pkg::MAX_FRAME) begin
			len_eff = ffb_pkg::CNT_W'(ffb_pkg::MAX_FRAME);
		end else if (int'(frame_length) < ffb_pkg::MIN_FRAME) begin
			len_eff = ffb_pkg::CNT_W'(ffb_pkg::MIN_FRAME);
		end else begin
			len_eff = ffb_pkg::CNT_W'(frame_length);
		end
	end

	assign body   = ffb_pkg::POS_W'(len_eff - ffb_pkg::CNT_W'(ffb_pkg::TRAILER_LEN));
	assign t_full = position_q - body;
	// a length change mid-frame can push the index past the end
	assign t_idx  = (t_full > ffb_pkg::POS_W'(15)) ? 4'd15 : t_full[3:0];
	assign padlen = (body > count_q) ? body - count_q : '0;

	assign type_cur   = filling_q ? held_type_q : frame_type;
	assign flag_cur   = filling_q ? held_flag_q : first_flag;
	assign offset_cur = filling_q ? held_offset_q : frame_offset;

	always_comb begin
		entry      = '0;
		position_n = position_q;
		count_n    = count_q;
		sum_n      = sum_q;
		filling_n  = filling_q;
		if (!mode) begin
			if (filling_q || count_q >= body) begin
				entry.dropped = 1'b1;
			end else begin
				entry.byte_val = data_byte;
				count_n        = count_q + 1'b1;
				sum_n          = sum_q + data_byte;
				position_n     = position_q + 1'b1;
			end
		end else begin
			filling_n = 1'b1;
			if (position_q < body) begin
				entry.byte_val = pad_char;
				position_n     = position_q + 1'b1;
			end else begin
				priority if (t_idx == 4'd0) begin
					entry.byte_val = type_cur;
				end else if (t_idx == 4'd1) begin
					entry.byte_val = flag_cur ? ffb_pkg::ASCII_ONE : ffb_pkg::ASCII_ZERO;
				end else if (t_idx <= 4'd8) begin
					entry.is_digit  = 1'b1;
					entry.value     = offset_cur;
					entry.digit_idx = ffb_pkg::IDX_W'(4'd8 - t_idx);
				end else if (t_idx <= 4'd11) begin
					entry.is_digit  = 1'b1;
					entry.value     = ffb_pkg::VAL_W'(sum_q);
					entry.digit_idx = ffb_pkg::IDX_W'(4'd11 - t_idx);
				end else begin
					entry.is_digit  = 1'b1;
					entry.value     = ffb_pkg::VAL_W'(padlen);
					entry.digit_idx = ffb_pkg::IDX_W'(4'd15 - t_idx);
				end
				if (t_idx == 4'd15) begin
					entry.last = 1'b1;
					position_n = '0;
					count_n    = '0;
					sum_n      = '0;
					filling_n  = 1'b0;
				end else begin
					position_n = position_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q    <= '0;
			count_q       <= '0;
			sum_q         <= '0;
			filling_q     <= 1'b0;
			held_type_q   <= '0;
			held_flag_q   <= 1'b0;
			held_offset_q <= '0;
		end else if (accept) begin
			position_q <= position_n;
			count_q    <= count_n;
			sum_q      <= sum_n;
			filling_q  <= filling_n;
			// header fields are taken on the first fill transfer of a frame
			if (mode && !filling_q) begin
				held_type_q   <= frame_type;
				held_flag_q   <= first_flag;
				held_offset_q <= frame_offset;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ffb_queue.sv
`default_nettype none

module ffb_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ffb_pkg::entry_t   push_entry,
	input  wire logic              pop,
	output ffb_pkg::entry_t        head,
	output ffb_pkg::queue_status_t status
);

	ffb_pkg::entry_t                    slots_q [ffb_pkg::QUEUE_DEPTH];
	logic [ffb_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [ffb_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [ffb_pkg::QUEUE_CNT_W-1:0]    level_q;

	assign head         = slots_q[rd_ptr_q];
	assign status.level = level_q;
	assign status.full  = (level_q == ffb_pkg::QUEUE_CNT_W'(ffb_pkg::QUEUE_DEPTH));
	assign status.empty = (level_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ffb_back.sv
`default_nettype none

module ffb_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ffb_pkg::entry_t head,
	input  wire logic            head_valid,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           out_byte,
	output logic                 last_of_frame,
	output logic                 dropped
);

	logic advance;

	logic                      valid_s1;
	logic                      is_digit_s1;
	logic [7:0]                byte_s1;
	logic                      last_s1;
	logic                      dropped_s1;
	logic [ffb_pkg::VAL_W-1:0] quot_s1;

	logic                      valid_s2;
	logic                      is_digit_s2;
	logic [7:0]                byte_s2;
	logic                      last_s2;
	logic                      dropped_s2;
	logic [3:0]                quot_lo_s2;
	logic [3:0]                tens_lo_s2;

	logic                      out_valid_q;
	logic [7:0]                out_byte_q;
	logic                      last_q;
	logic                      dropped_q;

	logic [ffb_pkg::PROD_W-1:0]              prod;
	logic [ffb_pkg::VAL_W+ffb_pkg::DIV10_W-1:0] prod10;
	logic [3:0]                              digit;

	assign advance = !out_valid_q || out_ready;
	assign pop     = advance && head_valid;

	// stage 1: v / 10^k by reciprocal multiply
	assign prod = ffb_pkg::PROD_W'(head.value) *
		ffb_pkg::PROD_W'(ffb_pkg::recip_of(head.digit_idx));

	// stage 2: quotient / 10, only the low bits are needed for the remainder
	assign prod10 = (ffb_pkg::VAL_W + ffb_pkg::DIV10_W)'(quot_s1) *
		(ffb_pkg::VAL_W + ffb_pkg::DIV10_W)'(ffb_pkg::DIV10_M);

	// remainder is 0..9 so four bits of the difference are exact
	assign digit = quot_lo_s2 - 4'(tens_lo_s2 * 4'd10);

	always_ff @(posedge clk) begin
		if (advance) begin
			is_digit_s1 <= head.is_digit;
			byte_s1     <= head.byte_val;
			last_s1     <= head.last;
			dropped_s1  <= head.dropped;
			quot_s1     <= ffb_pkg::VAL_W'(prod >> ffb_pkg::shift_of(head.digit_idx));

			is_digit_s2 <= is_digit_s1;
			byte_s2     <= byte_s1;
			last_s2     <= last_s1;
			dropped_s2  <= dropped_s1;
			quot_lo_s2  <= quot_s1[3:0];
			tens_lo_s2  <= prod10[ffb_pkg::DIV10_SHIFT +: 4];

			out_byte_q  <= is_digit_s2 ? ffb_pkg::ASCII_ZERO + {4'd0, digit} : byte_s2;
			last_q      <= last_s2;
			dropped_q   <= dropped_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign last_of_frame = last_q;
	assign dropped       = dropped_q;

endmodule

`default_nettype wire
